### rtl/falu_pkg.sv
package falu_pkg;

   localparam int XLEN = 64;
   localparam int HLEN = 32;

   typedef enum logic [2:0] {
      ACT_ADD      = 3'd0,
      ACT_SUB      = 3'd1,
      ACT_MUL      = 3'd2,
      ACT_DIV      = 3'd3,
      ACT_FRACTION = 3'd4,
      ACT_WHOLE    = 3'd5,
      ACT_TO_INT   = 3'd6,
      ACT_FROM_INT = 3'd7
   } action_type;

   typedef struct packed {
      action_type        action;
      logic              wide;
      logic              div_by_zero;
      logic              quot_neg;
      logic [XLEN-1:0]   simple;
      logic [XLEN-1:0]   prod_lo;
      logic [HLEN-1:0]   prod_cross;
   } side_type;

   typedef struct packed {
      logic [XLEN-1:0] rem;
      logic [XLEN-1:0] num_quot;
      logic [XLEN-1:0] den;
   } div_type;

endpackage

### rtl/falu_prep.sv
module falu_prep (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   in_valid,
   input  logic [2:0]             action,
   input  logic                   wide,
   input  logic                   is_signed,
   input  logic [63:0]            operand_a,
   input  logic [63:0]            operand_b,
   output logic                   out_valid,
   output falu_pkg::side_type     out_side,
   output falu_pkg::div_type      out_div
);

   logic                  valid_ff;
   falu_pkg::side_type    side_ff, side_in;
   falu_pkg::div_type     div_ff, div_in;
   falu_pkg::action_type  act;
   logic [63:0]           mask, fmask, a, b, sa, sb, num, sum, dif;
   logic                  num_neg, den_neg;

   always_comb begin
      act     = falu_pkg::action_type'(action);
      mask    = wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
      fmask   = wide ? 64'h0000_0000_FFFF_FFFF : 64'h0000_0000_0000_FFFF;
      a       = operand_a & mask;
      b       = operand_b & mask;
      sa      = wide ? {{16{is_signed & a[63]}}, a[63:16]}
                     : {32'b0, {8{is_signed & a[31]}}, a[31:8]};
      sb      = wide ? {{16{is_signed & b[63]}}, b[63:16]}
                     : {32'b0, {8{is_signed & b[31]}}, b[31:8]};
      num     = wide ? {a[47:0], 16'b0} : {32'b0, a[23:0], 8'b0};
      num_neg = is_signed & (wide ? num[63] : num[31]);
      den_neg = is_signed & (wide ? b[63] : b[31]);
      sum     = (a + b) & mask;
      dif     = (a - b) & mask;

      side_in.action      = act;
      side_in.wide        = wide;
      side_in.div_by_zero = (act == falu_pkg::ACT_DIV) && (b == 64'b0);
      side_in.quot_neg    = num_neg ^ den_neg;
      side_in.prod_lo     = 64'(sa[31:0]) * 64'(sb[31:0]);
      side_in.prod_cross  = 32'(sa[31:0] * sb[63:32]) + 32'(sa[63:32] * sb[31:0]);
      case (act)
         falu_pkg::ACT_ADD:      side_in.simple = sum;
         falu_pkg::ACT_SUB:      side_in.simple = dif;
         falu_pkg::ACT_FRACTION: side_in.simple = a & fmask;
         falu_pkg::ACT_WHOLE:    side_in.simple = a & mask & ~fmask;
         falu_pkg::ACT_TO_INT:   side_in.simple = wide
               ? {{32{is_signed & a[63]}}, a[63:32]}
               : {32'b0, {16{is_signed & a[31]}}, a[31:16]};
         falu_pkg::ACT_FROM_INT: side_in.simple = wide
               ? {a[31:0], 32'b0} : {32'b0, a[15:0], 16'b0};
         default:                side_in.simple = 64'b0;
      endcase

      div_in.rem      = 64'b0;
      div_in.num_quot = num_neg ? ((64'b0 - num) & mask) : num;
      div_in.den      = den_neg ? ((64'b0 - b) & mask) : b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= side_in;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_div   = div_ff;

endmodule

### rtl/falu_cell.sv
module falu_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  falu_pkg::side_type  in_side,
   input  falu_pkg::div_type   in_div,
   output logic                out_valid,
   output falu_pkg::side_type  out_side,
   output falu_pkg::div_type   out_div
);

   logic                valid_ff;
   falu_pkg::side_type  side_ff;
   falu_pkg::div_type   div_ff, div_in;
   logic [64:0]         rem_sh;
   logic                ge;

   always_comb begin
      rem_sh          = {in_div.rem, in_div.num_quot[63]};
      ge              = rem_sh >= {1'b0, in_div.den};
      div_in.rem      = ge ? 64'(rem_sh - {1'b0, in_div.den}) : rem_sh[63:0];
      div_in.num_quot = {in_div.num_quot[62:0], ge};
      div_in.den      = in_div.den;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff <= in_side;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_div   = div_ff;

endmodule

### rtl/fixed_point_alu.sv
// Every action passes the prep register, a 64-cell restoring divider chain and the
// result register before rsp_valid. Throughput: one item per cycle when not stalled.
// The whole pipeline holds while rsp_valid is high and rsp_stall is high.
// Reset (synchronous, active high) clears all stage valid bits; no item is lost
// or created by it beyond those in flight.
module fixed_point_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic        req_wide,
   input  logic        req_is_signed,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result,
   output logic        rsp_div_by_zero
);

   localparam int NCELL = falu_pkg::XLEN;

   logic                advance;
   logic                vld   [NCELL+1];
   falu_pkg::side_type  side  [NCELL+1];
   falu_pkg::div_type   divs  [NCELL+1];

   logic                rsp_valid_ff;
   logic [63:0]         result_ff, result_in;
   logic                dz_ff;
   falu_pkg::side_type  last;
   logic [63:0]         mask, prod, quot, quot_sh;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   falu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .action    (req_action),
      .wide      (req_wide),
      .is_signed (req_is_signed),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .out_valid (vld[0]),
      .out_side  (side[0]),
      .out_div   (divs[0])
   );

   for (genvar i = 0; i < NCELL; i++) begin : g_cell
      falu_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (vld[i]),
         .in_side   (side[i]),
         .in_div    (divs[i]),
         .out_valid (vld[i+1]),
         .out_side  (side[i+1]),
         .out_div   (divs[i+1])
      );
   end

   always_comb begin
      last    = side[NCELL];
      mask    = last.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
      prod    = (last.prod_lo + {last.prod_cross, 32'b0}) & mask;
      quot    = (last.quot_neg ? (64'b0 - divs[NCELL].num_quot)
                               : divs[NCELL].num_quot) & mask;
      quot_sh = last.wide ? {quot[47:0], 16'b0} : {32'b0, quot[23:0], 8'b0};
      case (last.action)
         falu_pkg::ACT_MUL: result_in = prod;
         falu_pkg::ACT_DIV: result_in = last.div_by_zero ? 64'b0 : quot_sh;
         default:           result_in = last.simple;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= vld[NCELL];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
         dz_ff     <= last.div_by_zero;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = result_ff;
   assign rsp_div_by_zero = dz_ff;

`ifndef NO_ASSERTIONS
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_div_by_zero |-> rsp_result == 64'b0)
      else $error("divide by zero with nonzero result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("pipeline advanced while result held");

   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
